// ===== rtl/stftms_pkg.sv =====
// Shared types, constants and constant ROM tables of the STFT magnitude block.
package stftms_pkg;

    localparam int FFT_LEN   = 64;
    localparam int HALF_LEN  = FFT_LEN / 2;
    localparam int HANN_DEN  = FFT_LEN - 1;
    localparam int IDX_W     = $clog2(FFT_LEN);
    localparam int SEEN_W    = IDX_W + 1;
    localparam int HOP_W     = 11;
    localparam int SAMPLE_W  = 16;
    localparam int WIN_W     = 16;
    localparam int TW_W      = 32;
    localparam int PROD_W    = WIN_W + TW_W;
    localparam int ACC_W     = 53;
    localparam int R15_W     = ACC_W - 30;
    localparam int SQ_W      = 44;
    localparam int MAG_W     = SQ_W / 2;
    localparam int FRAME_W   = 16;
    localparam int BIN_W     = 6;
    localparam int HANN_W    = 17;

    localparam logic [HOP_W-1:0] HOP_RESET = 11'd32;

    localparam longint unsigned PIHALF_Q30 = 64'd1686629713;
    localparam longint          ONE_Q30    = 64'sd1073741824;

    localparam longint unsigned CosDiv [8] = '{2, 12, 30, 56, 90, 132, 182, 240};
    localparam longint unsigned SinDiv [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       signal_start;
    } t_in_beat;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_index;
        logic [BIN_W-1:0]   bin_index;
        logic [MAG_W-1:0]   magnitude;
        logic               last_bin;
    } t_out_beat;

    typedef struct packed {
        longint c;
        longint s;
    } t_trig;

    typedef logic signed [TW_W-1:0] t_tw_rom [FFT_LEN];
    typedef logic [HANN_W-1:0]      t_hann_rom [FFT_LEN];

    // Taylor cos/sin of 2*pi*m/d in Q30, d is FFT_LEN or HANN_DEN.
    function automatic t_trig trig(input int unsigned m, input logic hann);
        longint unsigned p;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned tc;
        longint unsigned ts;
        longint          c;
        longint          s;
        logic [1:0]      quad;
        t_trig           res;
        int              i;
        if (hann) begin
            p = ((64'(m % HANN_DEN) << 32) + HANN_DEN / 2) / HANN_DEN;
        end else begin
            p = ((64'(m % FFT_LEN) << 32) + FFT_LEN / 2) / FFT_LEN;
        end
        p    = p & 64'hFFFF_FFFF;
        quad = p[31:30];
        r    = p & 64'h3FFF_FFFF;
        x    = (r * PIHALF_Q30 + (64'd1 << 29)) >> 30;
        x2   = (x * x) >> 30;
        tc   = 64'(ONE_Q30);
        ts   = x;
        c    = longint'(tc);
        s    = longint'(ts);
        for (i = 0; i < 8; i++) begin
            tc = ((tc * x2) >> 30) / CosDiv[i];
            ts = ((ts * x2) >> 30) / SinDiv[i];
            if (i % 2 == 0) begin
                c = c - longint'(tc);
                s = s - longint'(ts);
            end else begin
                c = c + longint'(tc);
                s = s + longint'(ts);
            end
        end
        if (c > ONE_Q30) c = ONE_Q30;
        if (c < -ONE_Q30) c = -ONE_Q30;
        if (s > ONE_Q30) s = ONE_Q30;
        if (s < -ONE_Q30) s = -ONE_Q30;
        case (quad)
            2'd0:    begin res.c = c;  res.s = s;  end
            2'd1:    begin res.c = -s; res.s = c;  end
            2'd2:    begin res.c = -c; res.s = -s; end
            default: begin res.c = s;  res.s = -c; end
        endcase
        return res;
    endfunction

    function automatic t_tw_rom build_cos();
        t_tw_rom rom;
        t_trig   t;
        for (int n = 0; n < FFT_LEN; n++) begin
            t      = trig(n, 1'b0);
            rom[n] = TW_W'(t.c);
        end
        return rom;
    endfunction

    function automatic t_tw_rom build_sin();
        t_tw_rom rom;
        t_trig   t;
        for (int n = 0; n < FFT_LEN; n++) begin
            t      = trig(n, 1'b0);
            rom[n] = TW_W'(t.s);
        end
        return rom;
    endfunction

    function automatic t_hann_rom build_hann();
        t_hann_rom rom;
        t_trig     t;
        for (int n = 0; n < FFT_LEN; n++) begin
            t      = trig(n, 1'b1);
            rom[n] = HANN_W'((ONE_Q30 - t.c + 64'sd32768) >>> 16);
        end
        return rom;
    endfunction

    localparam t_tw_rom   COS_ROM  = build_cos();
    localparam t_tw_rom   SIN_ROM  = build_sin();
    localparam t_hann_rom HANN_ROM = build_hann();

endpackage

// ===== rtl/stftms_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module stftms_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/stftms_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
module stftms_isqrt
    import stftms_pkg::*;
#(
    parameter int RAD_W = SQ_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [RAD_W-1:0]     i_radicand,
    output logic                 o_done,
    output logic [RAD_W/2-1:0]   o_root
);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int CNT_W  = $clog2(ROOT_W);

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [REM_W-1:0]  n_rem_sh;
    logic [REM_W-1:0]  n_trial;
    logic              n_fit;

    always_comb begin
        n_rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        n_trial  = REM_W'({r_root, 2'b01});
        n_fit    = (n_rem_sh >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNT_W'(ROOT_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            if (n_fit) begin
                r_rem  <= n_rem_sh - n_trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= n_rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_done |-> !r_busy)
        else $error("isqrt done while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start) |=> (r_busy || r_done))
        else $error("isqrt stopped without done");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_start |=> r_busy)
        else $error("isqrt start not taken");
endmodule

// ===== rtl/stft_magnitude_spectrogram.sv =====
// Top level of the STFT magnitude spectrogram block with Hann window.
//
// Samples (signed Q1.15) are taken one beat at a time into a 64-entry ring RAM.
// Frames of 64 samples end every hop_size samples, counted from a beat marked
// signal_start; only whole frames are used. A sample that does not close a
// frame is taken without a stall. A sample that closes a frame starts the frame
// engine and the input stalls until all 33 bins are handed to the output
// register: a window pass (ring RAM -> Hann multiply -> work RAM), then per
// bin a 64-step multiply-accumulate over the work RAM on one cos/sin
// multiplier pair, rounding, squaring and an iterative square root. Each
// output beat carries frame_index, bin_index (0 = DC .. 32 = Nyquist),
// magnitude in unsigned Q.15 and last_bin on the Nyquist bin. hop_size is
// written through i_cfg_we/i_cfg_wdata; the user must write it only while
// the block is idle, which the block itself does not enforce. 0 acts as 1
// and the value is loaded when a frame closes. The output register lets the
// next samples be taken while the last bin still waits downstream.
module stft_magnitude_spectrogram
    import stftms_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_beat         i_in_beat,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_beat        o_out_beat,
    input  logic             i_cfg_we,
    input  logic [HOP_W-1:0] i_cfg_wdata
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_WIN  = 8'b0000_0010,
        S_MAC  = 8'b0000_0100,
        S_RND  = 8'b0000_1000,
        S_SQ   = 8'b0001_0000,
        S_SUM  = 8'b0010_0000,
        S_ROOT = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(64'd1 << 29);

    t_state r_state;

    // frame bookkeeping
    logic [HOP_W-1:0]   r_hop;
    logic [SEEN_W-1:0]  r_seen;
    logic [HOP_W-1:0]   r_tfe;
    logic [FRAME_W-1:0] r_fc;
    logic [FRAME_W-1:0] r_frame_idx;
    logic [IDX_W-1:0]   r_wp;
    logic [IDX_W-1:0]   r_base;

    // engine
    logic [IDX_W:0]            r_cnt;
    logic [IDX_W-1:0]          r_ph;
    logic [IDX_W-1:0]          r_ph_d;
    logic                      r_rd_v;
    logic                      r_rd_last;
    logic [IDX_W-1:0]          r_rd_n;
    logic                      r_p_v;
    logic                      r_p_last;
    logic signed [PROD_W-1:0]  r_pre;
    logic signed [PROD_W-1:0]  r_pim;
    logic signed [ACC_W-1:0]   r_acc_re;
    logic signed [ACC_W-1:0]   r_acc_im;
    logic signed [R15_W-1:0]   r_r15;
    logic signed [R15_W-1:0]   r_i15;
    logic [SQ_W-1:0]           r_sq_re;
    logic [SQ_W-1:0]           r_sq_im;
    logic [BIN_W-1:0]          r_k;
    logic [MAG_W-1:0]          r_mag;

    logic                      r_out_valid;
    t_out_beat                 r_out_beat;

    // input-side next values
    logic               in_acc;
    logic [SEEN_W-1:0]  n_seen_s;
    logic [SEEN_W-1:0]  n_seen;
    logic [HOP_W-1:0]   n_tfe_s;
    logic [HOP_W-1:0]   n_tfe;
    logic [FRAME_W-1:0] n_fc_s;
    logic               n_fire;
    logic [HOP_W-1:0]   hop_eff;

    // memories and datapath
    logic [WIN_W-1:0]          ring_rd;
    logic [WIN_W-1:0]          work_rd;
    logic                      work_we;
    logic signed [WIN_W-1:0]   win_v;
    logic signed [33:0]        win_full;
    logic                      issue;
    logic signed [ACC_W-1:0]   rnd_re;
    logic signed [ACC_W-1:0]   rnd_im;
    logic                      out_free;
    logic                      sqrt_done;
    logic [MAG_W-1:0]          sqrt_root;

    assign in_acc  = i_in_valid && (r_state == S_IDLE);
    assign hop_eff = (r_hop == '0) ? HOP_W'(1) : r_hop;

    always_comb begin
        n_seen_s = i_in_beat.signal_start ? '0 : r_seen;
        n_seen   = (n_seen_s == SEEN_W'(FFT_LEN)) ? n_seen_s : n_seen_s + SEEN_W'(1);
        n_tfe_s  = i_in_beat.signal_start ? HOP_W'(FFT_LEN) : r_tfe;
        n_tfe    = (n_tfe_s != '0) ? n_tfe_s - HOP_W'(1) : '0;
        n_fc_s   = i_in_beat.signal_start ? '0 : r_fc;
        n_fire   = (n_tfe == '0) && (n_seen == SEEN_W'(FFT_LEN));
    end

    // window: v = floor((x*w + 2^14) / 2^15)
    always_comb begin
        win_full = $signed(ring_rd) * $signed({1'b0, HANN_ROM[r_rd_n]}) + 34'sd16384;
        win_v    = WIN_W'(win_full >>> 15);
    end

    assign work_we  = r_rd_v && (r_state == S_WIN);
    assign issue    = !r_cnt[IDX_W];
    assign rnd_re   = r_acc_re + ACC_RND;
    assign rnd_im   = r_acc_im + ACC_RND;
    assign out_free = !r_out_valid || !i_out_stall;

    stftms_ram #(.W(SAMPLE_W), .DEPTH(FFT_LEN)) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_wp),
        .i_wdata (i_in_beat.sample),
        .i_raddr (r_base + r_cnt[IDX_W-1:0]),
        .o_rdata (ring_rd)
    );

    stftms_ram #(.W(WIN_W), .DEPTH(FFT_LEN)) u_work (
        .i_clk   (i_clk),
        .i_we    (work_we),
        .i_waddr (r_rd_n),
        .i_wdata (win_v),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (work_rd)
    );

    stftms_isqrt #(.RAD_W(SQ_W)) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_SUM),
        .i_radicand (r_sq_re + r_sq_im),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hop       <= HOP_RESET;
            r_seen      <= '0;
            r_tfe       <= HOP_W'(FFT_LEN);
            r_fc        <= '0;
            r_wp        <= '0;
            r_cnt       <= '0;
            r_rd_v      <= 1'b0;
            r_rd_last   <= 1'b0;
            r_p_v       <= 1'b0;
            r_p_last    <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_hop <= i_cfg_wdata;
            end
            r_rd_v    <= issue && (r_state == S_WIN || r_state == S_MAC);
            r_rd_last <= issue && (r_state == S_MAC) &&
                         (r_cnt[IDX_W-1:0] == IDX_W'(FFT_LEN - 1));
            r_p_v     <= r_rd_v && (r_state == S_MAC);
            r_p_last  <= r_rd_last;
            // output register: filled from S_OUT, emptied when the beat is taken
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_wp   <= r_wp + IDX_W'(1);
                        r_seen <= n_seen;
                        if (n_fire) begin
                            r_tfe   <= hop_eff;
                            r_fc    <= n_fc_s + FRAME_W'(1);
                            r_cnt   <= '0;
                            r_state <= S_WIN;
                        end else begin
                            r_tfe <= n_tfe;
                            r_fc  <= n_fc_s;
                        end
                    end
                end
                S_WIN: begin
                    if (r_rd_v && r_rd_n == IDX_W'(FFT_LEN - 1)) begin
                        r_cnt   <= '0;
                        r_k     <= '0;
                        r_state <= S_MAC;
                    end else if (issue) begin
                        r_cnt <= r_cnt + (IDX_W+1)'(1);
                    end
                end
                S_MAC: begin
                    if (issue) begin
                        r_cnt <= r_cnt + (IDX_W+1)'(1);
                    end
                    if (r_p_v && r_p_last) begin
                        r_state <= S_RND;
                    end
                end
                S_RND:  r_state <= S_SQ;
                S_SQ:   r_state <= S_SUM;
                S_SUM:  r_state <= S_ROOT;
                S_ROOT: begin
                    if (sqrt_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        if (r_k == BIN_W'(HALF_LEN)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + BIN_W'(1);
                            r_cnt   <= '0;
                            r_state <= S_MAC;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc && n_fire) begin
            r_frame_idx <= n_fc_s;
            r_base      <= r_wp + IDX_W'(1);
        end
        r_rd_n <= r_cnt[IDX_W-1:0];
        r_ph_d <= r_ph;
        if (r_state == S_MAC && issue) begin
            r_ph <= r_ph + r_k[IDX_W-1:0];
        end else if (r_state != S_MAC) begin
            r_ph <= '0;
        end
        r_pre <= $signed(work_rd) * COS_ROM[r_ph_d];
        r_pim <= $signed(work_rd) * SIN_ROM[r_ph_d];
        if (r_state != S_MAC) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_p_v) begin
            r_acc_re <= r_acc_re + ACC_W'(r_pre);
            r_acc_im <= r_acc_im - ACC_W'(r_pim);
        end
        if (r_state == S_RND) begin
            r_r15 <= rnd_re[ACC_W-1:30];
            r_i15 <= rnd_im[ACC_W-1:30];
        end
        if (r_state == S_SQ) begin
            r_sq_re <= SQ_W'(r_r15 * r_r15);
            r_sq_im <= SQ_W'(r_i15 * r_i15);
        end
        if (sqrt_done) begin
            r_mag <= sqrt_root;
        end
        if (r_state == S_OUT && out_free) begin
            r_out_beat.frame_index <= r_frame_idx;
            r_out_beat.bin_index   <= r_k;
            r_out_beat.magnitude   <= r_mag;
            r_out_beat.last_bin    <= (r_k == BIN_W'(HALF_LEN));
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.last_bin) |-> (o_out_beat.bin_index == BIN_W'(HALF_LEN)))
        else $error("last_bin on a bin other than Nyquist");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && in_acc && n_fire) |=> (r_seen == SEEN_W'(FFT_LEN)))
        else $error("frame started before the ring was full");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_done |-> (r_state == S_ROOT))
        else $error("square root finished outside its state");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= BIN_W'(HALF_LEN))
        else $error("bin counter beyond Nyquist");
endmodule
